// ----- src/adjacency_matrix_graph_traversal_assert.svh -----
// assertion macros shared by the traversal engine
`ifndef ADJACENCY_MATRIX_GRAPH_TRAVERSAL_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_TRAVERSAL_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define AGT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define AGT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/agt_pkg.sv -----
package agt_pkg;

   // built graph size and derived widths
   localparam int MAX_V  = 16;
   localparam int VIDX_W = $clog2(MAX_V);
   localparam int CNT_W  = VIDX_W + 1;

   // command codes
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_EDGE  = 2'd1,
      OP_WALK  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   // configuration register indexes
   localparam logic CSR_VCOUNT = 1'b0;
   localparam logic CSR_MODE   = 1'b1;

   // walk modes
   localparam logic MODE_BFS = 1'b0;
   localparam logic MODE_DFS = 1'b1;

   // one queue or stack entry
   typedef struct packed {
      logic [VIDX_W-1:0] vertex;
      logic [CNT_W-1:0]  scan;
   } pend_entry_type;

   // sequencer states
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_EDGE   = 13'b0000000000010,
      S_BREAD  = 13'b0000000000100,
      S_BROW   = 13'b0000000001000,
      S_BCAND  = 13'b0000000010000,
      S_BPUSH  = 13'b0000000100000,
      S_DTOP   = 13'b0000001000000,
      S_DROW   = 13'b0000010000000,
      S_DFIND  = 13'b0000100000000,
      S_DPUSH1 = 13'b0001000000000,
      S_DPUSH2 = 13'b0010000000000,
      S_FIN    = 13'b0100000000000,
      S_SPARE  = 13'b1000000000000
   } state_type;

   // index of the lowest set bit (zero when none)
   function automatic logic [VIDX_W-1:0] lowest_set(input logic [MAX_V-1:0] v);
      logic [VIDX_W-1:0] idx;
      idx = '0;
      for (int i = MAX_V - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = VIDX_W'(i);
         end
      end
      return idx;
   endfunction

   // mask of bits below a count
   function automatic logic [MAX_V-1:0] below_mask(input logic [CNT_W-1:0] n);
      logic [MAX_V:0] t;
      t = ({{MAX_V{1'b0}}, 1'b1} << n) - 1'b1;
      return t[MAX_V-1:0];
   endfunction

endpackage

// ----- src/agt_ram.sv -----
module agt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/adjacency_matrix_graph_traversal.sv -----
// Graph traversal engine over a 16-vertex directed adjacency bit matrix held in a
// RAM (row r = outgoing edges of vertex r). Commands on req_ one at a time: clear
// (a per-row valid bit drops so rows read as empty), edge write (read-modify-write
// of one row), and traverse (breadth-first or depth-first pre-order from
// start_vertex, neighbors in ascending order, only vertices below vertex_count).
// Each visited vertex comes out once on rsp_, in visit order, with rsp_tlast on
// the final one; an out-of-range start gives no output. A traversal is paced by
// the chained registered reads of the queue/stack RAM and then the matrix RAM;
// output backpressure stalls it further. The next command is taken once the walk
// has handed its last vertex to the output register. Configuration writes are for
// the user to make only while the block is idle; the block does not enforce this.
`include "adjacency_matrix_graph_traversal_assert.svh"

module adjacency_matrix_graph_traversal
   import agt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // opcode[1:0], from_vertex[5:2], to_vertex[9:6], edge_present[10], start_vertex[14:11]
   input  logic [15:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // visited_vertex[3:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   // request fields
   opcode_type        req_opcode;
   logic [VIDX_W-1:0] req_from;
   logic [VIDX_W-1:0] req_to;
   logic              req_present;
   logic [VIDX_W-1:0] req_start;

   assign req_opcode  = opcode_type'(req_tdata[1:0]);
   assign req_from    = req_tdata[5:2];
   assign req_to      = req_tdata[9:6];
   assign req_present = req_tdata[10];
   assign req_start   = req_tdata[14:11];

   // registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  vc_ff, vc_in;
   logic              mode_ff, mode_in;
   logic [MAX_V-1:0]  row_vld_ff, row_vld_in;
   logic [MAX_V-1:0]  visited_ff, visited_in;
   logic [MAX_V-1:0]  cand_ff, cand_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [VIDX_W-1:0] u_ff, u_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [VIDX_W-1:0] j_ff, j_in;
   logic [VIDX_W-1:0] hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;
   logic [VIDX_W-1:0] ew_col_ff, ew_col_in;
   logic              ew_set_ff, ew_set_in;
   logic [VIDX_W-1:0] adj_raddr_ff, adj_raddr_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [VIDX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic              rsp_last_ff, rsp_last_in;

   // memory ports
   logic              adj_we, adj_re;
   logic [VIDX_W-1:0] adj_waddr, adj_raddr;
   logic [MAX_V-1:0]  adj_wdata, adj_rdata;
   logic              pend_we, pend_re;
   logic [VIDX_W-1:0] pend_waddr, pend_raddr;
   pend_entry_type    pend_wdata, pend_rdata;

   // helpers
   logic [CNT_W-1:0]  n_eff;
   logic [MAX_V-1:0]  n_mask;
   logic [MAX_V-1:0]  eff_row;
   logic [MAX_V-1:0]  dfs_cand;
   logic [CNT_W-1:0]  top_m1;
   logic              out_free;
   logic              emit;
   logic [VIDX_W-1:0] emit_vertex;
   logic              emit_last;
   logic [VIDX_W-1:0] pick;

   agt_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   agt_ram #(.WIDTH($bits(pend_entry_type)), .DEPTH(MAX_V)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_waddr),
      .wr_data (pend_wdata),
      .rd_en   (pend_re),
      .rd_addr (pend_raddr),
      .rd_data (pend_rdata)
   );

   // effective vertex count and masks
   assign n_eff    = (vc_ff > CNT_W'(MAX_V)) ? CNT_W'(MAX_V) : vc_ff;
   assign n_mask   = below_mask(n_eff);
   assign eff_row  = row_vld_ff[adj_raddr_ff] ? adj_rdata : '0;
   assign dfs_cand = eff_row & ~visited_ff & n_mask & ~below_mask(scan_ff);
   assign top_m1   = top_ff - 1'b1;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign pick     = (state_ff == S_DFIND) ? lowest_set(dfs_cand) : lowest_set(cand_ff);

   // configuration writes
   always_comb begin
      vc_in   = vc_ff;
      mode_in = mode_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_VCOUNT: vc_in   = csr_wdata;
            CSR_MODE:   mode_in = csr_wdata[0];
            default:    vc_in   = vc_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      row_vld_in    = row_vld_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      top_in        = top_ff;
      u_in          = u_ff;
      scan_in       = scan_ff;
      j_in          = j_ff;
      hold_in       = hold_ff;
      hold_vld_in   = hold_vld_ff;
      ew_col_in     = ew_col_ff;
      ew_set_in     = ew_set_ff;
      adj_we        = 1'b0;
      adj_waddr     = adj_raddr_ff;
      adj_wdata     = eff_row;
      adj_re        = 1'b0;
      adj_raddr     = req_from;
      pend_we       = 1'b0;
      pend_waddr    = '0;
      pend_wdata    = '0;
      pend_re       = 1'b0;
      pend_raddr    = '0;
      emit          = 1'b0;
      emit_vertex   = hold_ff;
      emit_last     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_opcode)
                  OP_CLEAR: row_vld_in = '0;
                  OP_EDGE: begin
                     adj_re    = 1'b1;
                     adj_raddr = req_from;
                     ew_col_in = req_to;
                     ew_set_in = req_present;
                     state_in  = S_EDGE;
                  end
                  OP_WALK: begin
                     visited_in = '0;
                     if ({1'b0, req_start} < n_eff) begin
                        visited_in  = MAX_V'(1) << req_start;
                        pend_we     = 1'b1;
                        pend_waddr  = '0;
                        pend_wdata  = '{vertex: req_start, scan: '0};
                        head_in     = '0;
                        tail_in     = CNT_W'(1);
                        top_in      = CNT_W'(1);
                        hold_in     = req_start;
                        hold_vld_in = (mode_ff == MODE_DFS);
                        state_in    = (mode_ff == MODE_DFS) ? S_DTOP : S_BREAD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // write back the modified row
         S_EDGE: begin
            adj_we    = 1'b1;
            adj_waddr = adj_raddr_ff;
            adj_wdata = ew_set_ff ? (eff_row | (MAX_V'(1) << ew_col_ff))
                                  : (eff_row & ~(MAX_V'(1) << ew_col_ff));
            row_vld_in[adj_raddr_ff] = 1'b1;
            state_in  = S_IDLE;
         end
         // breadth-first: dequeue
         S_BREAD: begin
            if (head_ff == tail_ff) begin
               state_in = S_FIN;
            end else begin
               pend_re    = 1'b1;
               pend_raddr = head_ff[VIDX_W-1:0];
               head_in    = head_ff + 1'b1;
               state_in   = S_BROW;
            end
         end
         // release the previous vertex, fetch the row of the new one
         S_BROW: begin
            if (!hold_vld_ff || out_free) begin
               emit        = hold_vld_ff;
               hold_in     = pend_rdata.vertex;
               hold_vld_in = 1'b1;
               adj_re      = 1'b1;
               adj_raddr   = pend_rdata.vertex;
               state_in    = S_BCAND;
            end
         end
         S_BCAND: begin
            cand_in  = eff_row & ~visited_ff & n_mask;
            state_in = S_BPUSH;
         end
         // enqueue unvisited neighbors, lowest first
         S_BPUSH: begin
            if (cand_ff != '0) begin
               pend_we          = 1'b1;
               pend_waddr       = tail_ff[VIDX_W-1:0];
               pend_wdata       = '{vertex: pick, scan: '0};
               tail_in          = tail_ff + 1'b1;
               visited_in[pick] = 1'b1;
               cand_in[pick]    = 1'b0;
            end else begin
               state_in = S_BREAD;
            end
         end
         // depth-first: read the top of the stack
         S_DTOP: begin
            if (top_ff == '0) begin
               state_in = S_FIN;
            end else begin
               pend_re    = 1'b1;
               pend_raddr = top_m1[VIDX_W-1:0];
               state_in   = S_DROW;
            end
         end
         S_DROW: begin
            u_in      = pend_rdata.vertex;
            scan_in   = pend_rdata.scan;
            adj_re    = 1'b1;
            adj_raddr = pend_rdata.vertex;
            state_in  = S_DFIND;
         end
         // next unvisited neighbor at or past the scan position
         S_DFIND: begin
            if (dfs_cand != '0 && top_ff < CNT_W'(MAX_V)) begin
               j_in     = pick;
               state_in = S_DPUSH1;
            end else begin
               top_in   = top_m1;
               state_in = S_DTOP;
            end
         end
         S_DPUSH1: begin
            pend_we    = 1'b1;
            pend_waddr = top_m1[VIDX_W-1:0];
            pend_wdata = '{vertex: u_ff, scan: {1'b0, j_ff} + 1'b1};
            state_in   = S_DPUSH2;
         end
         S_DPUSH2: begin
            if (out_free) begin
               pend_we          = 1'b1;
               pend_waddr       = top_ff[VIDX_W-1:0];
               pend_wdata       = '{vertex: j_ff, scan: '0};
               top_in           = top_ff + 1'b1;
               visited_in[j_ff] = 1'b1;
               emit             = 1'b1;
               hold_in          = j_ff;
               state_in         = S_DTOP;
            end
         end
         // final vertex of the walk
         S_FIN: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_last   = 1'b1;
               hold_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      adj_raddr_in = adj_re ? adj_raddr : adj_raddr_ff;
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_vertex_in = emit_vertex;
         rsp_last_in   = emit_last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vc_ff         <= CNT_W'(MAX_V);
         mode_ff       <= MODE_BFS;
         row_vld_ff    <= '0;
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         top_ff        <= '0;
         hold_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vc_ff         <= vc_in;
         mode_ff       <= mode_in;
         row_vld_ff    <= row_vld_in;
         visited_ff    <= visited_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         top_ff        <= top_in;
         hold_vld_ff   <= hold_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      u_ff          <= u_in;
      scan_ff       <= scan_in;
      j_ff          <= j_in;
      hold_ff       <= hold_in;
      ew_col_ff     <= ew_col_in;
      ew_set_ff     <= ew_set_in;
      adj_raddr_ff  <= adj_raddr_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(8 - VIDX_W){1'b0}}, rsp_vertex_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `AGT_ASSERT_NEXT(a_clear_drops_rows, req_tvalid && req_tready && req_opcode == OP_CLEAR, row_vld_ff == '0, "clear left a row valid")
   `AGT_ASSERT_NOW(a_queue_room, state_ff == S_BPUSH && cand_ff != '0, tail_ff < CNT_W'(MAX_V), "queue overflow")
   `AGT_ASSERT_NOW(a_dfs_fresh, state_ff == S_DPUSH2, !visited_ff[j_ff], "stack push of a visited vertex")
   `AGT_ASSERT_NOW(a_fin_has_vertex, state_ff == S_FIN, hold_vld_ff, "walk ends with no vertex held")

endmodule
